@@ design/u2a_pkg.sv @@
// Shared types, constants and the code point fold function for the UTF-8 to ASCII folder.
// No dependencies; used by the step logic and by the top level.
package u2a_pkg;

  localparam logic [15:0] CAP_RESET  = 16'd256;
  localparam logic [6:0]  CHAR_QMARK = 7'h3F;
  localparam logic [6:0]  CHAR_SPACE = 7'h20;
  localparam logic [6:0]  CHAR_NUL   = 7'h00;

  typedef struct packed {
    logic [20:0] partial;
    logic [1:0]  pending;
    logic [15:0] written;
  } state_t;

  typedef struct packed {
    logic [6:0]  ch;
    logic        is_end;
    logic [15:0] count;
  } res_t;

  typedef struct packed {
    res_t [2:0] res;
    logic [1:0] cnt;
  } emit_t;

  typedef struct packed {
    logic [1:0] len;
    logic [6:0] c0;
    logic [6:0] c1;
    logic [6:0] c2;
  } fold_t;

  function automatic fold_t mk(input logic [1:0] len, input logic [7:0] a,
                               input logic [7:0] b, input logic [7:0] c);
    fold_t f;
    f.len = len;
    f.c0  = a[6:0];
    f.c1  = b[6:0];
    f.c2  = c[6:0];
    return f;
  endfunction

  // Latin-1 letters U+00C0..U+00FF
  function automatic fold_t latin_fold(input logic [5:0] idx);
    fold_t f;
    case (idx) inside
      [6'd0:6'd5]:   f = mk(2'd1, "A", 8'd0, 8'd0);
      6'd6:          f = mk(2'd2, "A", "E", 8'd0);
      6'd7:          f = mk(2'd1, "C", 8'd0, 8'd0);
      [6'd8:6'd11]:  f = mk(2'd1, "E", 8'd0, 8'd0);
      [6'd12:6'd15]: f = mk(2'd1, "I", 8'd0, 8'd0);
      6'd16:         f = mk(2'd1, "D", 8'd0, 8'd0);
      6'd17:         f = mk(2'd1, "N", 8'd0, 8'd0);
      [6'd18:6'd22]: f = mk(2'd1, "O", 8'd0, 8'd0);
      6'd23:         f = mk(2'd1, "x", 8'd0, 8'd0);
      6'd24:         f = mk(2'd1, "O", 8'd0, 8'd0);
      [6'd25:6'd28]: f = mk(2'd1, "U", 8'd0, 8'd0);
      6'd29:         f = mk(2'd1, "Y", 8'd0, 8'd0);
      6'd30:         f = mk(2'd2, "T", "h", 8'd0);
      6'd31:         f = mk(2'd2, "s", "s", 8'd0);
      [6'd32:6'd37]: f = mk(2'd1, "a", 8'd0, 8'd0);
      6'd38:         f = mk(2'd2, "a", "e", 8'd0);
      6'd39:         f = mk(2'd1, "c", 8'd0, 8'd0);
      [6'd40:6'd43]: f = mk(2'd1, "e", 8'd0, 8'd0);
      [6'd44:6'd47]: f = mk(2'd1, "i", 8'd0, 8'd0);
      6'd48:         f = mk(2'd1, "d", 8'd0, 8'd0);
      6'd49:         f = mk(2'd1, "n", 8'd0, 8'd0);
      [6'd50:6'd54]: f = mk(2'd1, "o", 8'd0, 8'd0);
      6'd55:         f = mk(2'd1, "/", 8'd0, 8'd0);
      6'd56:         f = mk(2'd1, "o", 8'd0, 8'd0);
      [6'd57:6'd60]: f = mk(2'd1, "u", 8'd0, 8'd0);
      6'd61:         f = mk(2'd1, "y", 8'd0, 8'd0);
      6'd62:         f = mk(2'd2, "t", "h", 8'd0);
      default:       f = mk(2'd1, "y", 8'd0, 8'd0);
    endcase
    return f;
  endfunction

  function automatic fold_t fold_point(input logic [20:0] cp);
    fold_t f;
    case (cp) inside
      [21'h0000C0:21'h0000FF]: f = latin_fold(cp[5:0]);
      21'h0000A0: f = mk(2'd1, " ", 8'd0, 8'd0);
      21'h0000A1: f = mk(2'd1, "!", 8'd0, 8'd0);
      21'h0000BF: f = mk(2'd1, "?", 8'd0, 8'd0);
      21'h0000AB: f = mk(2'd2, "<", "<", 8'd0);
      21'h0000BB: f = mk(2'd2, ">", ">", 8'd0);
      21'h0000B7: f = mk(2'd1, ".", 8'd0, 8'd0);
      21'h002018, 21'h002019, 21'h00201B, 21'h002032:
        f = mk(2'd1, "'", 8'd0, 8'd0);
      21'h00201C, 21'h00201D, 21'h002033:
        f = mk(2'd1, "\"", 8'd0, 8'd0);
      [21'h002010:21'h002015], 21'h002212:
        f = mk(2'd1, "-", 8'd0, 8'd0);
      21'h002026: f = mk(2'd3, ".", ".", ".");
      21'h002022: f = mk(2'd1, "*", 8'd0, 8'd0);
      21'h000152: f = mk(2'd2, "O", "E", 8'd0);
      21'h000153: f = mk(2'd2, "o", "e", 8'd0);
      21'h000160: f = mk(2'd1, "S", 8'd0, 8'd0);
      21'h000161: f = mk(2'd1, "s", 8'd0, 8'd0);
      21'h00017D: f = mk(2'd1, "Z", 8'd0, 8'd0);
      21'h00017E: f = mk(2'd1, "z", 8'd0, 8'd0);
      21'h000178: f = mk(2'd1, "Y", 8'd0, 8'd0);
      default:    f = mk(2'd1, "?", 8'd0, 8'd0);
    endcase
    return f;
  endfunction

  // room for one more character before the terminator slot
  function automatic logic has_room(input logic [15:0] w, input logic [15:0] cap);
    return ({1'b0, w} + 17'd1) < {1'b0, cap};
  endfunction

  function automatic res_t char_res(input logic [6:0] ch);
    res_t r;
    r.ch     = ch;
    r.is_end = 1'b0;
    r.count  = 16'd0;
    return r;
  endfunction

endpackage

@@ design/u2a_if.sv @@
// Handshake channel interfaces for the UTF-8 to ASCII folder: byte input and character output.
// No dependencies.
interface u2a_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u2a_char_if;
  logic        valid;
  logic        ready;
  logic [6:0]  out_char;
  logic        is_end;
  logic [15:0] char_count;
  modport source (output valid, output out_char, output is_end, output char_count, input ready);
  modport sink   (input valid, input out_char, input is_end, input char_count, output ready);
endinterface

@@ design/u2a_step.sv @@
// Per-byte decode: next decoder state and up to three result words for one input byte.
// Depends on u2a_pkg (state, result and fold types, fold table).
module u2a_step (
  input  u2a_pkg::state_t st,
  input  logic [7:0]      in_byte,
  input  logic [15:0]     cap,
  output u2a_pkg::state_t st_next,
  output u2a_pkg::emit_t  emit
);
  import u2a_pkg::*;

  logic [20:0] cp_full;
  fold_t       fl;
  logic [1:0]  k;
  logic [15:0] wc;
  logic        cont;

  assign cp_full = {st.partial[14:0], in_byte[5:0]};
  assign fl      = fold_point(cp_full);
  assign cont    = (in_byte[7:6] == 2'b10);

  always_comb begin
    st_next  = st;
    emit     = '0;
    k        = 2'd0;
    wc       = st.written;
    if (st.pending != 2'd0 && cont) begin
      st_next.partial = cp_full;
      st_next.pending = st.pending - 2'd1;
      if (st.pending == 2'd1) begin
        st_next.partial = '0;
        // each folded character checks room on its own
        if (fl.len >= 2'd1 && has_room(wc, cap)) begin
          emit.res[k] = char_res(fl.c0);
          k  = k + 2'd1;
          wc = wc + 16'd1;
        end
        if (fl.len >= 2'd2 && has_room(wc, cap)) begin
          emit.res[k] = char_res(fl.c1);
          k  = k + 2'd1;
          wc = wc + 16'd1;
        end
        if (fl.len == 2'd3 && has_room(wc, cap)) begin
          emit.res[k] = char_res(fl.c2);
          k  = k + 2'd1;
          wc = wc + 16'd1;
        end
      end
      st_next.written = wc;
    end else begin
      // no sequence continues: flag one that was cut short, then treat the byte afresh
      if (st.pending != 2'd0) begin
        if (has_room(wc, cap)) begin
          emit.res[k] = char_res(CHAR_QMARK);
          k  = k + 2'd1;
          wc = wc + 16'd1;
        end
        st_next.pending = 2'd0;
        st_next.partial = '0;
      end
      st_next.written = wc;
      if (in_byte == 8'd0) begin
        emit.res[k].ch     = CHAR_NUL;
        emit.res[k].is_end = 1'b1;
        emit.res[k].count  = wc;
        k = k + 2'd1;
        st_next.written = '0;
        st_next.partial = '0;
        st_next.pending = 2'd0;
      end else if (has_room(wc, cap)) begin
        if (in_byte < 8'h80) begin
          emit.res[k] = char_res((in_byte >= 8'h20 && in_byte < 8'h7F) ?
                                 in_byte[6:0] : CHAR_SPACE);
          k = k + 2'd1;
          st_next.written = wc + 16'd1;
        end else if (in_byte[7:5] == 3'b110) begin
          st_next.partial = {16'd0, in_byte[4:0]};
          st_next.pending = 2'd1;
        end else if (in_byte[7:4] == 4'b1110) begin
          st_next.partial = {17'd0, in_byte[3:0]};
          st_next.pending = 2'd2;
        end else if (in_byte[7:3] == 5'b11110) begin
          st_next.partial = {18'd0, in_byte[2:0]};
          st_next.pending = 2'd3;
        end else begin
          emit.res[k] = char_res(CHAR_QMARK);
          k = k + 2'd1;
          st_next.written = wc + 16'd1;
        end
      end
    end
    emit.cnt = k;
  end

endmodule

@@ design/utf8_to_ascii_folder_top.sv @@
// Top level of the UTF-8 to ASCII folder: state and capacity registers, result queue.
// Depends on u2a_pkg, u2a_if (u2a_byte_if, u2a_char_if) and u2a_step.
//
//   port         dir   words                         handshake
//   in_ch        in    in_byte[7:0]                  valid/ready
//   out_ch       out   out_char, is_end, char_count  valid/ready
//   cfg_wr_*     in    buffer_capacity[15:0]         write enable only
//
// An input byte is decoded in the cycle it is accepted; its results sit in a
// three-entry result register and leave one per cycle, from the next cycle on,
// while the output is ready. A byte giving zero or one word then sustains one
// byte per cycle; a fold to two or three characters holds the input while the queue drains.
// Reset (rst, synchronous) clears the decoder state and sets capacity to 256.
// A stalled output holds the head word and stops input while any word waits.
module utf8_to_ascii_folder_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [15:0]     cfg_wr_data,
  u2a_byte_if.sink        in_ch,
  u2a_char_if.source      out_ch
);
  import u2a_pkg::*;

  state_t      st;
  state_t      st_next;
  emit_t       emit;
  logic [15:0] cap;
  res_t        q [3];
  logic [1:0]  qcnt;
  logic        in_fire;
  logic        out_fire;

  u2a_step u_step (
    .st      (st),
    .in_byte (in_ch.in_byte),
    .cap     (cap),
    .st_next (st_next),
    .emit    (emit)
  );

  assign in_ch.ready = (qcnt == 2'd0) || (qcnt == 2'd1 && out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  assign out_ch.valid      = (qcnt != 2'd0);
  assign out_ch.out_char   = q[0].ch;
  assign out_ch.is_end     = q[0].is_end;
  assign out_ch.char_count = q[0].count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= '0;
      qcnt <= 2'd0;
    end else if (in_fire) begin
      st   <= st_next;
      qcnt <= emit.cnt;
    end else if (out_fire) begin
      qcnt <= qcnt - 2'd1;
    end
  end

  // queue payload: load fresh results, or advance one word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      q[0] <= emit.res[0];
      q[1] <= emit.res[1];
      q[2] <= emit.res[2];
    end else if (out_fire) begin
      q[0] <= q[1];
      q[1] <= q[2];
    end
  end

  a_partial_clear: assert property (@(posedge clk) disable iff (rst)
    st.pending == 2'd0 |-> st.partial == 21'd0)
    else $error("partial code point left over with no sequence open");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    st.written != 16'hFFFF)
    else $error("written count out of range");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.in_byte == 8'd0 |=> st.written == 16'd0 && st.pending == 2'd0)
    else $error("terminator did not clear string state");

  a_empty_after_drop: assert property (@(posedge clk) disable iff (rst)
    in_fire && emit.cnt == 2'd0 |=> !out_ch.valid)
    else $error("stale word left after a byte with no result");

  a_end_nul: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.is_end |-> out_ch.out_char == CHAR_NUL)
    else $error("terminator word carries a character");

endmodule
